// ===== design/bsp_pkg.sv =====
package bsp_pkg;

  localparam int STEP_BITS = 16;
  localparam int DLY_W     = 16;
  localparam int ERR_W     = STEP_BITS + 2;
  localparam int IDX_W     = STEP_BITS + 1;
  localparam int RAMP_W    = STEP_BITS - 2;
  localparam int PROD_W    = DLY_W + RAMP_W;
  localparam int MCNT_W    = $clog2(RAMP_W);
  localparam int DCNT_W    = $clog2(PROD_W);
  localparam int CFG_IDX_W = 1;

  localparam logic [DLY_W-1:0] MIN_DELAY_RESET = DLY_W'(300);
  localparam logic [DLY_W-1:0] MAX_DELAY_RESET = DLY_W'(500);
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DELAY = 1'b0,
    REG_MAX_DELAY = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic dir_a;
    logic dir_b;
    logic step_axis;
    logic last_of_item;
    logic move_done;
  } result_t;

endpackage

// ===== design/bsp_mul.sv =====
module bsp_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bsp_pkg::DLY_W-1:0]    mcand,
  input  logic [bsp_pkg::RAMP_W-1:0]   mplier,
  output logic                         done,
  output logic [bsp_pkg::PROD_W-1:0]   product
);
  import bsp_pkg::*;

  localparam logic [MCNT_W-1:0] MUL_LAST = MCNT_W'(RAMP_W - 1);

  logic              busy;
  logic [MCNT_W-1:0] cnt;
  logic [DLY_W-1:0]  mc;
  logic [PROD_W-1:0] acc;
  logic [DLY_W:0]    sum;

  assign sum     = {1'b0, acc[PROD_W-1:RAMP_W]} + (acc[0] ? {1'b0, mc} : {(DLY_W+1){1'b0}});
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= mcand;
      acc <= {{DLY_W{1'b0}}, mplier};
    end else if (busy) begin
      acc <= {sum, acc[RAMP_W-1:1]};
    end
  end

endmodule

// ===== design/bsp_div.sv =====
module bsp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bsp_pkg::PROD_W-1:0]   dividend,
  input  logic [bsp_pkg::RAMP_W-1:0]   divisor,
  output logic                         done,
  output logic [bsp_pkg::DLY_W-1:0]    quotient
);
  import bsp_pkg::*;

  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(PROD_W - 1);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [RAMP_W-1:0] dv;
  logic [RAMP_W-1:0] rem;
  logic [PROD_W-1:0] quo;
  logic [RAMP_W:0]   trial;
  logic [RAMP_W:0]   diff;
  logic              fits;

  assign trial    = {rem, quo[PROD_W-1]};
  assign diff     = trial - {1'b0, dv};
  assign fits     = trial >= {1'b0, dv};
  assign quotient = quo[DLY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

endmodule

// ===== design/ramped_bresenham_step_planner.sv =====
// Channel  Handshake               Payload
// in       in_valid / in_stall     req_type, delta_x, delta_y, x_positive, y_positive
// out      out_valid / out_stall   dir_a, dir_b, half_period_us, step_axis,
//                                  last_of_item, move_done
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A load request, or a step request that yields no step, leaves the FSM in
// the idle state. A step request after the ramp goes straight to the emit
// state; inside the ramp it first passes the bit-serial multiplier and the
// restoring divider that form the half-period, one bit per cycle each.
// Reset is synchronous; no clearing pass follows it.
// Up to two results wait in an output buffer while the next request is taken;
// a new set of results is loaded only once that buffer is empty.
module ramped_bresenham_step_planner (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [bsp_pkg::STEP_BITS-1:0]   delta_x,
  input  logic [bsp_pkg::STEP_BITS-1:0]   delta_y,
  input  logic                            x_positive,
  input  logic                            y_positive,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            dir_a,
  output logic                            dir_b,
  output logic [bsp_pkg::DLY_W-1:0]       half_period_us,
  output logic                            step_axis,
  output logic                            last_of_item,
  output logic                            move_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsp_pkg::DLY_W-1:0]       cfg_data
);
  import bsp_pkg::*;

  logic [DLY_W-1:0]     min_delay_us;
  logic [DLY_W-1:0]     max_delay_us;

  logic                 move_active;
  logic [STEP_BITS-1:0] target_x;
  logic [STEP_BITS-1:0] target_y;
  logic [STEP_BITS-1:0] done_x;
  logic [STEP_BITS-1:0] done_y;
  logic [ERR_W-1:0]     line_error;
  logic [IDX_W-1:0]     iteration_index;
  logic [RAMP_W-1:0]    ramp_length;
  logic [1:0]           sign_bits;

  state_t               state;
  state_t               state_next;

  result_t              pend0;
  result_t              pend1;
  logic [1:0]           pend_n;
  logic                 use_ramp;

  result_t              obuf0;
  result_t              obuf1;
  logic [DLY_W-1:0]     odly;
  logic [1:0]           ocnt;

  logic                 in_acc;
  logic                 out_acc;
  logic                 step_req;
  logic [ERR_W:0]       e2;
  logic [ERR_W:0]       ext_dx;
  logic [ERR_W:0]       ext_dy;
  logic                 x_go;
  logic                 y_go;
  logic [ERR_W:0]       err_sum;
  logic [STEP_BITS-1:0] done_x_new;
  logic [STEP_BITS-1:0] done_y_new;
  logic                 complete;
  logic [1:0]           nres;
  logic                 ramp_now;
  result_t              x_res;
  result_t              y_res;
  logic [STEP_BITS-1:0] big_delta;

  logic [DLY_W:0]       ddiff;
  logic                 dneg;
  logic [DLY_W-1:0]     dmag;
  logic                 mul_start;
  logic                 mul_done;
  logic [PROD_W-1:0]    product;
  logic                 div_start;
  logic                 div_done;
  logic [DLY_W-1:0]     quotient;
  logic [DLY_W-1:0]     delay;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (ocnt != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign step_req  = in_acc && (req_type == REQ_STEP) && move_active;

  assign e2     = {line_error, 1'b0};
  assign ext_dx = {3'b000, target_x};
  assign ext_dy = {3'b000, target_y};
  assign x_go   = ($signed(e2) > -$signed(ext_dy)) && (done_x < target_x);
  assign y_go   = ($signed(e2) < $signed(ext_dx)) && (done_y < target_y);
  assign err_sum = {line_error[ERR_W-1], line_error}
                   - (x_go ? ext_dy : {(ERR_W+1){1'b0}})
                   + (y_go ? ext_dx : {(ERR_W+1){1'b0}});
  assign done_x_new = done_x + {{(STEP_BITS-1){1'b0}}, x_go};
  assign done_y_new = done_y + {{(STEP_BITS-1){1'b0}}, y_go};
  assign complete   = (done_x_new >= target_x) && (done_y_new >= target_y);
  assign nres       = {1'b0, x_go} + {1'b0, y_go};
  assign ramp_now   = iteration_index < {3'b000, ramp_length};
  assign big_delta  = (delta_x > delta_y) ? delta_x : delta_y;

  always_comb begin
    x_res = '{dir_a: sign_bits[0], dir_b: sign_bits[0], step_axis: 1'b0,
              last_of_item: !y_go, move_done: !y_go && complete};
    y_res = '{dir_a: !sign_bits[1], dir_b: sign_bits[1], step_axis: 1'b1,
              last_of_item: 1'b1, move_done: complete};
  end

  assign ddiff = {1'b0, max_delay_us} - {1'b0, min_delay_us};
  assign dneg  = ddiff[DLY_W];
  assign dmag  = dneg ? DLY_W'(-ddiff) : ddiff[DLY_W-1:0];
  assign delay = !use_ramp ? min_delay_us
               : (dneg ? max_delay_us + quotient : max_delay_us - quotient);

  bsp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (dmag),
    .mplier  (iteration_index[RAMP_W-1:0]),
    .done    (mul_done),
    .product (product)
  );

  bsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (ramp_length),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (step_req && nres != 2'd0) begin
          if (ramp_now) begin
            mul_start  = 1'b1;
            state_next = ST_MUL;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (ocnt == 2'd0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay_us <= MIN_DELAY_RESET;
      max_delay_us <= MAX_DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_DELAY: min_delay_us <= cfg_data;
        REG_MAX_DELAY: max_delay_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_active     <= 1'b0;
      target_x        <= '0;
      target_y        <= '0;
      done_x          <= '0;
      done_y          <= '0;
      line_error      <= '0;
      iteration_index <= '0;
      ramp_length     <= '0;
      sign_bits       <= '0;
    end else if (in_acc && req_type == REQ_LOAD) begin
      target_x        <= delta_x;
      target_y        <= delta_y;
      done_x          <= '0;
      done_y          <= '0;
      line_error      <= ERR_W'({2'b00, delta_x} - {2'b00, delta_y});
      iteration_index <= '0;
      ramp_length     <= big_delta[STEP_BITS-1:2];
      sign_bits       <= {y_positive, x_positive};
      move_active     <= (delta_x != '0) || (delta_y != '0);
    end else if (step_req) begin
      done_x     <= done_x_new;
      done_y     <= done_y_new;
      line_error <= err_sum[ERR_W-1:0];
      if (iteration_index != IDX_MAX) begin
        iteration_index <= iteration_index + 1'b1;
      end
      if (nres != 2'd0 && complete) begin
        move_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_req) begin
      pend0    <= x_go ? x_res : y_res;
      pend1    <= y_res;
      pend_n   <= nres;
      use_ramp <= ramp_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (state == ST_EMIT && ocnt == 2'd0) begin
      ocnt <= pend_n;
    end else if (out_acc) begin
      ocnt <= ocnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && ocnt == 2'd0) begin
      obuf0 <= pend0;
      obuf1 <= pend1;
      odly  <= delay;
    end else if (out_acc) begin
      obuf0 <= obuf1;
    end
  end

  assign dir_a          = obuf0.dir_a;
  assign dir_b          = obuf0.dir_b;
  assign step_axis      = obuf0.step_axis;
  assign last_of_item   = obuf0.last_of_item;
  assign move_done      = obuf0.move_done;
  assign half_period_us = odly;

endmodule
